>>> sv/assert_macros.svh
// assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/wcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wcs_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_R2,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  // configuration register indexes
  localparam logic [1:0] CFG_BEGIN_X = 2'd0;
  localparam logic [1:0] CFG_BEGIN_Y = 2'd1;
  localparam logic [1:0] CFG_END_X   = 2'd2;
  localparam logic [1:0] CFG_END_Y   = 2'd3;

  // line test term codes
  localparam logic [2:0] T_CROSS = 3'd0;
  localparam logic [2:0] T_S1    = 3'd1;
  localparam logic [2:0] T_S2    = 3'd2;
  localparam logic [2:0] T_S3    = 3'd3;
  localparam logic [2:0] T_S4    = 3'd4;

  // sign of a term
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // tag that travels with a product
  typedef struct packed {
    logic       vld;
    logic       r2;
    logic       half;
    logic [2:0] term;
    logic [1:0] edg;
  } tag_t;

  // two signs are not of the same strict sign
  function automatic logic opp(input sgn_t a, input sgn_t b);
    return a.zero | b.zero | (a.neg ^ b.neg);
  endfunction

endpackage
`default_nettype wire

>>> sv/window_crossing_selection_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one primitive at a time; the single shared multiplier issues one
// product per cycle (40 products for a line, 9 for a circle).
// A finished group result waits in the output register; a next group end waits for it.
// Reset (async, active low): corners 0, window flag set, hit flag clear, group count 0.
`include "assert_macros.svh"
module window_crossing_selection_test_top import wcs_pkg::*; #(
  parameter int MAX_GROUPS = 1024,
  parameter int COORD_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [COORD_BITS-1:0]       cfg_data_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         kind_i,
  input  wire  signed [COORD_BITS-1:0] point_a_x_i,
  input  wire  signed [COORD_BITS-1:0] point_a_y_i,
  input  wire  signed [COORD_BITS-1:0] point_b_x_i,
  input  wire  signed [COORD_BITS-1:0] point_b_y_i,
  input  wire  [COORD_BITS-2:0]       radius_i,
  input  wire                         last_in_group_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [9:0]                  group_number_o,
  output logic                        selected_o,
  output logic                        crossing_mode_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int TW = PW + 1;
  localparam int CW = PW + 2;
  localparam int GW = $clog2(MAX_GROUPS);
  localparam int OW = (GW > 10) ? GW : 10;
  localparam logic [GW-1:0] GMAX = GW'(MAX_GROUPS - 1);

  function automatic logic signed [DW-1:0] dif(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
    return {a[CB-1], a} - {b[CB-1], b};
  endfunction

  // configuration registers
  logic signed [CB-1:0] cbx_q, cby_q, cex_q, cey_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbx_q <= '0;
      cby_q <= '0;
      cex_q <= '0;
      cey_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BEGIN_X: cbx_q <= cfg_data_i;
        CFG_BEGIN_Y: cby_q <= cfg_data_i;
        CFG_END_X:   cex_q <= cfg_data_i;
        CFG_END_Y:   cey_q <= cfg_data_i;
        default:     cbx_q <= cbx_q;
      endcase
    end
  end

  state_e state_q, state_d;
  logic in_xfer, issue, is_r2, fin, fin_block, last_issue;
  logic [1:0] edge_q;
  logic [2:0] term_q;
  logic       half_q;

  // captured primitive
  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
  logic [CB-2:0] r_q;
  logic circ_q, last_q;

  assign in_xfer = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ax_q   <= point_a_x_i;
      ay_q   <= point_a_y_i;
      bx_q   <= point_b_x_i;
      by_q   <= point_b_y_i;
      r_q    <= radius_i;
      circ_q <= kind_i;
      last_q <= last_in_group_i;
    end
  end

  assign last_issue = (state_q == ST_RUN) && (edge_q == 2'd3) && half_q &&
                      (circ_q || (term_q == T_S4));
  assign fin_block  = last_q && out_valid_o && out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = kind_i ? ST_R2 : ST_RUN;
      ST_R2:    state_d = ST_RUN;
      ST_RUN:   if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   if (!fin_block) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    issue      = (state_q == ST_R2) || (state_q == ST_RUN);
    is_r2      = (state_q == ST_R2);
    fin        = (state_q == ST_FIN) && !fin_block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= '0;
      term_q <= T_CROSS;
      half_q <= 1'b0;
    end else if (in_xfer) begin
      edge_q <= '0;
      term_q <= T_CROSS;
      half_q <= 1'b0;
    end else if (state_q == ST_RUN) begin
      half_q <= ~half_q;
      if (half_q) begin
        if (circ_q || term_q == T_S4) begin
          term_q <= T_CROSS;
          edge_q <= edge_q + 2'd1;
        end else begin
          term_q <= term_q + 3'd1;
        end
      end
    end
  end

  // operand selection for the shared multiplier
  logic signed [CB-1:0] cx, cy, dx, dy, kx, ky;
  logic signed [DW-1:0] op_a, op_b, ux, uy, vx, vy;
  always_comb begin
    cx = edge_q[1] ? cex_q : cbx_q;
    cy = edge_q[1] ? cey_q : cby_q;
    dx = edge_q[0] ? cex_q : cbx_q;
    dy = edge_q[0] ? cby_q : cey_q;
    kx = edge_q[1] ? cex_q : cbx_q;
    ky = edge_q[0] ? cey_q : cby_q;
    ux = dif(bx_q, ax_q);
    uy = dif(by_q, ay_q);
    vx = dif(dx, cx);
    vy = dif(dy, cy);
    op_a = '0;
    op_b = '0;
    if (is_r2) begin
      op_a = DW'(r_q);
      op_b = DW'(r_q);
    end else if (circ_q) begin
      op_a = half_q ? dif(ay_q, ky) : dif(ax_q, kx);
      op_b = op_a;
    end else begin
      case (term_q)
        T_CROSS: begin
          op_a = half_q ? uy : ux;
          op_b = half_q ? vx : vy;
        end
        T_S1: begin
          op_a = half_q ? uy : ux;
          op_b = half_q ? dif(cx, ax_q) : dif(cy, ay_q);
        end
        T_S2: begin
          op_a = half_q ? uy : ux;
          op_b = half_q ? dif(dx, ax_q) : dif(dy, ay_q);
        end
        T_S3: begin
          op_a = half_q ? vy : vx;
          op_b = half_q ? dif(ax_q, cx) : dif(ay_q, cy);
        end
        T_S4: begin
          op_a = half_q ? vy : vx;
          op_b = half_q ? dif(bx_q, cx) : dif(by_q, cy);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  // product register with its tag
  logic signed [PW-1:0] p_q;
  tag_t t_q;
  always_ff @(posedge clk_i) begin
    p_q <= op_a * op_b;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else begin
      t_q.vld  <= issue;
      t_q.r2   <= is_r2;
      t_q.half <= half_q;
      t_q.term <= term_q;
      t_q.edg  <= edge_q;
    end
  end

  // accumulate pairs and take signs
  logic signed [PW-1:0] acc_q, r2_q;
  logic signed [TW-1:0] term_v;
  logic signed [CW-1:0] cval;
  sgn_t tsg, csg, s1_q, s2_q, s3_q;
  sgn_t cs_q [4];
  logic nz_q, hit_q, meet;

  always_comb begin
    term_v = circ_q ? (TW'(acc_q) + TW'(p_q)) : (TW'(acc_q) - TW'(p_q));
    cval   = CW'(term_v) - CW'(r2_q);
    tsg.neg  = term_v[TW-1];
    tsg.zero = (term_v == '0);
    csg.neg  = cval[CW-1];
    csg.zero = (cval == '0);
    meet = nz_q && opp(s1_q, s2_q) && opp(s3_q, tsg);
  end

  always_ff @(posedge clk_i) begin
    if (t_q.vld) begin
      if (t_q.r2) begin
        r2_q <= p_q;
      end else if (!t_q.half) begin
        acc_q <= p_q;
      end else if (circ_q) begin
        cs_q[t_q.edg] <= csg;
      end else begin
        case (t_q.term)
          T_CROSS: nz_q <= !tsg.zero;
          T_S1:    s1_q <= tsg;
          T_S2:    s2_q <= tsg;
          T_S3:    s3_q <= tsg;
          default: nz_q <= nz_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (in_xfer) begin
      hit_q <= 1'b0;
    end else if (t_q.vld && t_q.half && !t_q.r2 && !circ_q && t_q.term == T_S4) begin
      hit_q <= hit_q | meet;
    end
  end

  // inside test and group bookkeeping
  logic signed [CB:0] xlo, xhi, ylo, yhi, rr, axe, aye, bxe, bye;
  logic in_rect, chit, hit, crossing, all_n, any_n;
  always_comb begin
    xlo = (cbx_q < cex_q) ? DW'(cbx_q) : DW'(cex_q);
    xhi = (cbx_q < cex_q) ? DW'(cex_q) : DW'(cbx_q);
    ylo = (cby_q < cey_q) ? DW'(cby_q) : DW'(cey_q);
    yhi = (cby_q < cey_q) ? DW'(cey_q) : DW'(cby_q);
    rr  = DW'(r_q);
    axe = DW'(ax_q);
    aye = DW'(ay_q);
    bxe = DW'(bx_q);
    bye = DW'(by_q);
    if (circ_q) begin
      in_rect = (axe - rr >= xlo) && (axe + rr <= xhi) &&
                (aye - rr >= ylo) && (aye + rr <= yhi);
    end else begin
      in_rect = (axe >= xlo) && (axe <= xhi) && (aye >= ylo) && (aye <= yhi) &&
                (bxe >= xlo) && (bxe <= xhi) && (bye >= ylo) && (bye <= yhi);
    end
    chit = opp(cs_q[0], cs_q[1]) || opp(cs_q[0], cs_q[2]) ||
           opp(cs_q[3], cs_q[1]) || opp(cs_q[3], cs_q[2]);
    hit      = (circ_q ? chit : hit_q) || in_rect;
    crossing = !(cbx_q < cex_q);
  end

  logic all_q, any_q;
  logic [GW-1:0] cnt_q;
  logic [OW-1:0] cnt_ext;
  logic sel_q, mode_q;
  logic [9:0] grp_q;

  assign all_n = all_q && in_rect;
  assign any_n = any_q || hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q       <= 1'b1;
      any_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (fin && last_q) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (fin) begin
        if (last_q) begin
          all_q       <= 1'b1;
          any_q       <= 1'b0;
          cnt_q       <= (cnt_q == GMAX) ? '0 : cnt_q + 1'b1;
        end else begin
          all_q <= all_n;
          any_q <= any_n;
        end
      end
    end
  end

  assign cnt_ext = OW'(cnt_q);

  // result payload
  always_ff @(posedge clk_i) begin
    if (fin && last_q) begin
      grp_q  <= cnt_ext[9:0];
      sel_q  <= crossing ? any_n : all_n;
      mode_q <= crossing;
    end
  end

  assign group_number_o  = grp_q;
  assign selected_o      = sel_q;
  assign crossing_mode_o = mode_q;

  `ASSERT_NEXT(a_result_loaded, fin && last_q, out_valid_o)
  `ASSERT_SAME(a_no_product_idle, t_q.vld && !t_q.r2, state_q == ST_RUN || state_q == ST_DRAIN)
  `ASSERT_NEXT(a_count_moves, fin && last_q, cnt_q != $past(cnt_q))

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb import wcs_pkg::*; ();

  localparam int  CLK_HALF   = 6;
  localparam int  CYCLE_CAP  = 1000000;
  localparam int  SETTLE     = 60;
  localparam int  LONG_HOLD  = 2000;

  typedef struct {
    logic               kind;
    logic signed [15:0] ax, ay, bx, by;
    logic [14:0]        radius;
    logic               last;
  } prim_t;

  typedef struct {
    logic [9:0] grp;
    logic       sel;
    logic       xmode;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic signed [15:0] pa_x = '0, pa_y = '0, pb_x = '0, pb_y = '0;
  logic [14:0] radius = '0;
  logic last_in_group = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] group_number;
  logic selected;
  logic crossing_mode;

  // drag rectangle copy and running group flags
  logic signed [15:0] rect_bx = '0, rect_by = '0, rect_ex = '0, rect_ey = '0;
  bit all_in = 1'b1;
  bit any_hit = 1'b0;
  logic [9:0] grp_count = '0;

  prim_t    pend_prims[$];
  verdict_t group_verdicts[$];
  int       errors = 0;
  bit       long_req = 1'b0;

  window_crossing_selection_test_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .point_a_x_i     (pa_x),
    .point_a_y_i     (pa_y),
    .point_b_x_i     (pb_x),
    .point_b_y_i     (pb_y),
    .radius_i        (radius),
    .last_in_group_i (last_in_group),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .group_number_o  (group_number),
    .selected_o      (selected),
    .crossing_mode_o (crossing_mode)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // segment ab meets segment cd, not parallel, endpoints count
  function automatic bit segs_meet(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy, longint dx, longint dy);
    longint ux, uy, vx, vy;
    int s1, s2, s3, s4;
    ux = bx - ax; uy = by - ay;
    vx = dx - cx; vy = dy - cy;
    if (cross2(ux, uy, vx, vy) == 0) return 1'b0;
    s1 = sign_of(cross2(ux, uy, cx - ax, cy - ay));
    s2 = sign_of(cross2(ux, uy, dx - ax, dy - ay));
    s3 = sign_of(cross2(vx, vy, ax - cx, ay - cy));
    s4 = sign_of(cross2(vx, vy, bx - cx, by - cy));
    return (s1 * s2 <= 0) && (s3 * s4 <= 0);
  endfunction

  // edge pq has one end on or across the circle
  function automatic bit edge_touches(longint px, longint py, longint qx, longint qy,
                                      longint cx, longint cy, longint r);
    int s1, s2;
    s1 = sign_of((cx - px) * (cx - px) + (cy - py) * (cy - py) - r * r);
    s2 = sign_of((cx - qx) * (cx - qx) + (cy - qy) * (cy - qy) - r * r);
    return s1 * s2 <= 0;
  endfunction

  // fold one accepted primitive into the group, queue the verdict at group end
  function automatic void absorb_prim(prim_t p);
    longint bx, by, ex, ey, xlo, xhi, ylo, yhi, ax, ay, qx, qy, r;
    bit in_rect, hit, xmode;
    verdict_t v;
    bx = rect_bx; by = rect_by; ex = rect_ex; ey = rect_ey;
    xlo = (bx < ex) ? bx : ex; xhi = (bx < ex) ? ex : bx;
    ylo = (by < ey) ? by : ey; yhi = (by < ey) ? ey : by;
    ax = p.ax; ay = p.ay; qx = p.bx; qy = p.by; r = p.radius;
    xmode = !(bx < ex);
    if (p.kind) begin
      in_rect = ax - r >= xlo && ax + r <= xhi && ay - r >= ylo && ay + r <= yhi;
      hit = edge_touches(bx, by, bx, ey, ax, ay, r) || edge_touches(bx, by, ex, by, ax, ay, r)
         || edge_touches(ex, ey, bx, ey, ax, ay, r) || edge_touches(ex, ey, ex, by, ax, ay, r);
    end else begin
      in_rect = ax >= xlo && ax <= xhi && ay >= ylo && ay <= yhi
             && qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
      hit = segs_meet(ax, ay, qx, qy, bx, by, bx, ey) || segs_meet(ax, ay, qx, qy, bx, by, ex, by)
         || segs_meet(ax, ay, qx, qy, ex, ey, bx, ey) || segs_meet(ax, ay, qx, qy, ex, ey, ex, by);
    end
    all_in = all_in && in_rect;
    any_hit = any_hit || hit || in_rect;
    if (p.last) begin
      v.grp = grp_count;
      v.sel = xmode ? any_hit : all_in;
      v.xmode = xmode;
      group_verdicts = {group_verdicts, v};
      all_in = 1'b1;
      any_hit = 1'b0;
      grp_count = grp_count + 10'd1;
    end
  endfunction

  // driver: bursts of transfers with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk_i) begin
    bit took;
    took = in_valid && !in_stall;
    if (took) absorb_prim(pend_prims.pop_front());
    if (!in_valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_prims.size() > 0) begin
        in_valid      <= 1'b1;
        kind          <= pend_prims[0].kind;
        pa_x          <= pend_prims[0].ax;
        pa_y          <= pend_prims[0].ay;
        pb_x          <= pend_prims[0].bx;
        pb_y          <= pend_prims[0].by;
        radius        <= pend_prims[0].radius;
        last_in_group <= pend_prims[0].last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold on request
  int pat_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    pat_cnt++;
    if (long_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((pat_cnt / 150) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= pat_cnt[1];
      endcase
    end
  end

  // monitor: compare each result transfer with the oldest verdict
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid && !out_stall) begin
      if (group_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result group %0d", group_number));
      end else begin
        v = group_verdicts.pop_front();
        if (group_number !== v.grp)
          report_mismatch($sformatf("group_number %0d, want %0d", group_number, v.grp));
        if (selected !== v.sel)
          report_mismatch($sformatf("group %0d selected %b, want %b", v.grp, selected, v.sel));
        if (crossing_mode !== v.xmode)
          report_mismatch($sformatf("group %0d crossing_mode %b, want %b",
                                    v.grp, crossing_mode, v.xmode));
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_rect(input int bx, input int by, input int ex, input int ey);
    logic [15:0] vals[4];
    vals[0] = bx[15:0]; vals[1] = by[15:0]; vals[2] = ex[15:0]; vals[3] = ey[15:0];
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rect_bx = vals[CFG_BEGIN_X];
    rect_by = vals[CFG_BEGIN_Y];
    rect_ex = vals[CFG_END_X];
    rect_ey = vals[CFG_END_Y];
  endtask

  task automatic drain();
    while (pend_prims.size() > 0 || in_valid || group_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic prim_t mk(bit k, int ax, int ay, int bx, int by, int r, bit l);
    prim_t p;
    p.kind = k; p.ax = 16'(ax); p.ay = 16'(ay); p.bx = 16'(bx); p.by = 16'(by);
    p.radius = 15'(r); p.last = l;
    return p;
  endfunction

  // append one primitive to the pending queue
  function automatic void add_prim(prim_t p);
    pend_prims = {pend_prims, p};
  endfunction

  function automatic int near_coord(longint lo, longint hi);
    longint m, a, b;
    m = (hi - lo) / 2 + 32;
    a = lo - m; b = hi + m;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return int'(a + longint'($urandom_range(0, int'(b - a))));
  endfunction

  function automatic prim_t rand_prim(bit l);
    prim_t p;
    longint xlo, xhi, ylo, yhi;
    xlo = (rect_bx < rect_ex) ? rect_bx : rect_ex; xhi = (rect_bx < rect_ex) ? rect_ex : rect_bx;
    ylo = (rect_by < rect_ey) ? rect_by : rect_ey; yhi = (rect_by < rect_ey) ? rect_ey : rect_by;
    p.kind = 1'($urandom_range(0, 1));
    p.last = l;
    if ($urandom_range(0, 6) == 0) begin
      p.ax = 16'($urandom); p.ay = 16'($urandom); p.bx = 16'($urandom); p.by = 16'($urandom);
      p.radius = 15'($urandom);
    end else begin
      p.ax = 16'(near_coord(xlo, xhi)); p.ay = 16'(near_coord(ylo, yhi));
      p.bx = 16'(near_coord(xlo, xhi)); p.by = 16'(near_coord(ylo, yhi));
      p.radius = 15'($urandom_range(0, ((xhi - xlo) / 2 + 32 > 32767) ? 32767
                                       : int'((xhi - xlo) / 2 + 32)));
      // sometimes an axis-aligned line, parallel to the top and bottom sides of the rectangle
      if (!p.kind && $urandom_range(0, 7) == 0) p.by = p.ay;
    end
    return p;
  endfunction

  task automatic push_directed(input bit open_end);
    add_prim(mk(0, -16, -16, 16, 16, 5, 1));
    add_prim(mk(0, 0, 0, 320, 0, 0, 1));
    add_prim(mk(0, 200, 200, 300, 300, 0, 1));
    add_prim(mk(0, 160, -100, 160, 100, 0, 1));
    add_prim(mk(0, 0, 0, 0, 0, 0, 1));
    add_prim(mk(0, -32768, -32768, 32767, 32767, 32767, 1));
    add_prim(mk(1, 0, 0, 0, 0, 16, 1));
    add_prim(mk(1, 160, 0, -5, 7, 32, 1));
    add_prim(mk(1, 0, 0, 0, 0, 32767, 1));
    add_prim(mk(1, 160, 160, 0, 0, 0, 1));
    add_prim(mk(1, 32767, -32768, -1, -1, 0, 0));
    add_prim(mk(0, 10, 10, -10, -10, 0, !open_end));
  endtask

  task automatic push_random(input int n_items, input int single_pct);
    int left, sz;
    left = n_items;
    while (left > 0) begin
      sz = ($urandom_range(0, 99) < single_pct) ? 1 : $urandom_range(2, 4);
      if (sz > left) sz = left;
      for (int i = 0; i < sz; i++) add_prim(rand_prim(i == sz - 1));
      left -= sz;
    end
    // leave a group open across the next rectangle change now and then
    if ($urandom_range(0, 1)) add_prim(rand_prim(1'b0));
  endtask

  initial begin
    int rb[4];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, window then crossing, group left open across the mode change
    set_rect(-160, -160, 160, 160);
    push_directed(1'b1);
    drain();
    set_rect(160, -160, -160, 160);
    push_directed(1'b0);
    drain();

    // random phases over a spread of rectangles
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_rect(-32768, -32768, 32767, 32767);
        1: set_rect(32767, 32767, -32768, -32768);
        2: set_rect(100, -50, 100, 50);
        3: set_rect(-200, 30, 200, 30);
        default: begin
          for (int i = 0; i < 4; i++)
            rb[i] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                  : int'($urandom_range(0, 4000)) - 2000;
          set_rect(rb[0], rb[1], rb[2], rb[3]);
        end
      endcase
      push_random(100, 85);
      if (ph == 4) long_req = 1'b1;
      drain();
    end

    // many one-primitive groups so the group number wraps
    set_rect(-500, -400, 600, 300);
    push_random(400, 100);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
